/* hdl/vis_pkg.sv */
// ----------------------------------------------------------------------------
// vis_pkg: shared types and constants
// Widths, action and register codes, and the item records that travel
// between the stages of the voxel importance split/roulette block.
// ----------------------------------------------------------------------------
package vis_pkg;

  localparam int TableDepthDef = 4096;
  localparam int MaxSplitDef   = 64;

  localparam int CountW  = 9;
  localparam int CoordW  = 8;
  localparam int WordW   = 32;
  localparam int EntryW  = 12;
  localparam int CopyW   = 6;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = 2 * WordW;
  localparam int CyzW    = 2 * CountW;
  localparam int IdxW    = CoordW + CyzW + 1;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SPLIT   = 3'd1,
    ACT_KILL    = 3'd2,
    ACT_SURVIVE = 3'd3,
    ACT_LOAD    = 3'd4,
    ACT_ERROR   = 3'd5
  } vis_act_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COUNT_X = 2'd0,
    REG_COUNT_Y = 2'd1,
    REG_COUNT_Z = 2'd2
  } vis_reg_e;

  typedef struct packed {
    logic              req_type;
    logic [EntryW-1:0] entry_index;
    logic [WordW-1:0]  entry_importance;
    logic              crossing_limits;
    logic [CoordW-1:0] pre_x;
    logic [CoordW-1:0] pre_y;
    logic [CoordW-1:0] pre_z;
    logic [CoordW-1:0] post_x;
    logic [CoordW-1:0] post_y;
    logic [CoordW-1:0] post_z;
    logic [WordW-1:0]  track_weight;
    logic [WordW-1:0]  uniform_random;
  } vis_req_t;

  // item after index computation; decide marks a final action
  typedef struct packed {
    vis_act_e         act;
    logic             decide;
    logic [WordW-1:0] imp;
    logic [WordW-1:0] weight;
    logic [WordW-1:0] rnd;
  } vis_ev_t;

  // item after the importance classification and the products
  typedef struct packed {
    vis_act_e         act;
    logic [WordW-1:0] weight;
    logic [WordW-1:0] post;
    logic [WordW-1:0] pre;
    logic [ProdW-1:0] prod_w;
    logic [ProdW-1:0] prod_r;
  } vis_mid_t;

  // sideband through the split-count divider
  typedef struct packed {
    vis_act_e         act;
    logic [WordW-1:0] weight;
    logic [WordW-1:0] post;
    logic [ProdW-1:0] prod_w;
  } vis_sd_t;

  // sideband through the weight divider
  typedef struct packed {
    vis_act_e         act;
    logic [WordW-1:0] weight;
    logic [CopyW-1:0] copies;
  } vis_md_t;

endpackage

/* hdl/vis_if.sv */
// ----------------------------------------------------------------------------
// vis_if: channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface vis_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] entry_index;
  logic [31:0] entry_importance;
  logic        crossing_limits;
  logic [7:0]  pre_x;
  logic [7:0]  pre_y;
  logic [7:0]  pre_z;
  logic [7:0]  post_x;
  logic [7:0]  post_y;
  logic [7:0]  post_z;
  logic [31:0] track_weight;
  logic [31:0] uniform_random;

  modport source (
    output valid, req_type, entry_index, entry_importance, crossing_limits,
    output pre_x, pre_y, pre_z, post_x, post_y, post_z, track_weight, uniform_random,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_importance, crossing_limits,
    input  pre_x, pre_y, pre_z, post_x, post_y, post_z, track_weight, uniform_random,
    output ready
  );
endinterface

interface vis_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] new_weight;
  logic [5:0]  extra_copies;

  modport source (output valid, action, new_weight, extra_copies, input ready);
  modport sink   (input valid, action, new_weight, extra_copies, output ready);
endinterface

interface vis_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/vis_index.sv */
// ----------------------------------------------------------------------------
// vis_index: voxel index stages
// Input register, coordinate products, then index sums and range checks.
// ----------------------------------------------------------------------------
module vis_index import vis_pkg::*; #(
  parameter  int TABLE_DEPTH = TableDepthDef,
  localparam int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] count_x_i,
  input  logic [CountW-1:0] count_y_i,
  input  logic [CountW-1:0] count_z_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vis_req_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vis_ev_t           out_ev_o,
  output logic [AW-1:0]     out_pre_idx_o,
  output logic [AW-1:0]     out_post_idx_o
);

  localparam int XW = CoordW + CyzW;
  localparam int YW = CoordW + CountW;

  logic rdy0, rdy1, rdy2;
  logic r0_v_q, r1_v_q, r2_v_q;

  vis_req_t          r0_q, r1_q;
  logic [CyzW-1:0]   cyz_q;
  logic [XW-1:0]     pxa_d, qxa_d, r1_pxa_q, r1_qxa_q;
  logic [YW-1:0]     pyb_d, qyb_d, r1_pyb_q, r1_qyb_q;
  logic              oob_d, r1_oob_q;
  logic [IdxW-1:0]   pre_sum, post_sum;
  logic              ent_bad, idx_bad;
  vis_ev_t           ev_d, r2_ev_q;
  logic [AW-1:0]     pre_idx_d, r2_pre_q, r2_post_q;

  assign rdy2       = !r2_v_q | out_ready_i;
  assign rdy1       = !r1_v_q | rdy2;
  assign rdy0       = !r0_v_q | rdy1;
  assign in_ready_o = rdy0;

  // y*z plane size, follows the count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyz_q <= CyzW'(1);
    end else begin
      cyz_q <= CyzW'(count_y_i) * CyzW'(count_z_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_v_q <= 1'b0;
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
    end else begin
      if (rdy0) r0_v_q <= in_valid_i;
      if (rdy1) r1_v_q <= r0_v_q;
      if (rdy2) r2_v_q <= r1_v_q;
    end
  end

  assign pxa_d = XW'(r0_q.pre_x) * XW'(cyz_q);
  assign qxa_d = XW'(r0_q.post_x) * XW'(cyz_q);
  assign pyb_d = YW'(r0_q.pre_y) * YW'(count_z_i);
  assign qyb_d = YW'(r0_q.post_y) * YW'(count_z_i);
  assign oob_d = ({1'b0, r0_q.pre_x}  >= count_x_i) | ({1'b0, r0_q.pre_y}  >= count_y_i) |
                 ({1'b0, r0_q.pre_z}  >= count_z_i) | ({1'b0, r0_q.post_x} >= count_x_i) |
                 ({1'b0, r0_q.post_y} >= count_y_i) | ({1'b0, r0_q.post_z} >= count_z_i);

  assign pre_sum  = IdxW'(r1_pxa_q) + IdxW'(r1_pyb_q) + IdxW'(r1_q.pre_z);
  assign post_sum = IdxW'(r1_qxa_q) + IdxW'(r1_qyb_q) + IdxW'(r1_q.post_z);
  assign idx_bad  = r1_oob_q | (pre_sum >= IdxW'(TABLE_DEPTH)) |
                    (post_sum >= IdxW'(TABLE_DEPTH));
  assign ent_bad  = 32'(r1_q.entry_index) >= 32'(TABLE_DEPTH);

  always_comb begin
    ev_d.imp    = r1_q.entry_importance;
    ev_d.weight = r1_q.track_weight;
    ev_d.rnd    = r1_q.uniform_random;
    ev_d.decide = 1'b1;
    ev_d.act    = ACT_NONE;
    if (!r1_q.req_type) begin
      ev_d.act = ent_bad ? ACT_ERROR : ACT_LOAD;
    end else if (!r1_q.crossing_limits) begin
      ev_d.act = ACT_NONE;
    end else if (idx_bad) begin
      ev_d.act = ACT_ERROR;
    end else if (pre_sum == post_sum) begin
      ev_d.act = ACT_NONE;
    end else begin
      ev_d.decide = 1'b0;
      ev_d.act    = ACT_SURVIVE;
    end
  end

  // a load writes through the pre address
  assign pre_idx_d = r1_q.req_type ? AW'(pre_sum) : AW'(r1_q.entry_index);

  always_ff @(posedge clk_i) begin
    if (rdy0) r0_q <= in_req_i;
    if (rdy1) begin
      r1_q     <= r0_q;
      r1_pxa_q <= pxa_d;
      r1_qxa_q <= qxa_d;
      r1_pyb_q <= pyb_d;
      r1_qyb_q <= qyb_d;
      r1_oob_q <= oob_d;
    end
    if (rdy2) begin
      r2_ev_q   <= ev_d;
      r2_pre_q  <= pre_idx_d;
      r2_post_q <= AW'(post_sum);
    end
  end

  assign out_valid_o    = r2_v_q;
  assign out_ev_o       = r2_ev_q;
  assign out_pre_idx_o  = r2_pre_q;
  assign out_post_idx_o = r2_post_q;

endmodule

/* hdl/vis_table.sv */
// ----------------------------------------------------------------------------
// vis_table: importance table stage
// One write port for loads, two registered read ports for crossings.
// ----------------------------------------------------------------------------
module vis_table import vis_pkg::*; #(
  parameter  int TABLE_DEPTH = TableDepthDef,
  localparam int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vis_ev_t          ev_i,
  input  logic [AW-1:0]    pre_idx_i,
  input  logic [AW-1:0]    post_idx_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vis_ev_t          ev_o,
  output logic [WordW-1:0] pre_o,
  output logic [WordW-1:0] post_o
);

  logic [WordW-1:0] mem_q [TABLE_DEPTH];
  logic             v_q, rdy;
  vis_ev_t          ev_q;
  logic [WordW-1:0] pre_q, post_q;

  assign rdy        = !v_q | out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  // reads and writes happen as an item enters, so order is kept
  always_ff @(posedge clk_i) begin
    if (rdy) begin
      if (in_valid_i && ev_i.decide && ev_i.act == ACT_LOAD) begin
        mem_q[pre_idx_i] <= ev_i.imp;
      end
      pre_q  <= mem_q[pre_idx_i];
      post_q <= mem_q[post_idx_i];
      ev_q   <= ev_i;
    end
  end

  assign out_valid_o = v_q;
  assign ev_o        = ev_q;
  assign pre_o       = pre_q;
  assign post_o      = post_q;

endmodule

/* hdl/vis_div.sv */
// ----------------------------------------------------------------------------
// vis_div: pipelined restoring divider
// Input stage, then one quotient bit per stage; saturation flag, sideband.
// ----------------------------------------------------------------------------
module vis_div import vis_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [QW-1:0] quot_o,
  output logic          sat_o,
  output logic [SW-1:0] side_o
);

  localparam int TW = NW - QW;
  localparam int MW = (TW > DW) ? TW : DW;

  logic [QW:0]   v_q;
  logic [QW+1:0] rdy;
  logic [QW:0]   sat_q;
  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] lq_q   [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];
  logic [DW:0]   r2_w   [1:QW];
  logic [QW:1]   ge_w;

  assign rdy[QW+1]  = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k <= QW; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] | rdy[k+1];
  end

  // shift in the next numerator bit, subtract when it fits
  for (genvar k = 1; k <= QW; k++) begin : g_step
    assign r2_w[k] = {rem_q[k-1], lq_q[k-1][QW-1]};
    assign ge_w[k] = r2_w[k] >= {1'b0, den_q[k-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= QW; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      rem_q[0]  <= DW'(num_i[NW-1:QW]);
      lq_q[0]   <= num_i[QW-1:0];
      den_q[0]  <= den_i;
      sat_q[0]  <= MW'(num_i[NW-1:QW]) >= MW'(den_i);
      side_q[0] <= side_i;
    end
    for (int k = 1; k <= QW; k++) begin
      if (rdy[k]) begin
        rem_q[k]  <= ge_w[k] ? DW'(r2_w[k] - {1'b0, den_q[k-1]}) : DW'(r2_w[k]);
        lq_q[k]   <= {lq_q[k-1][QW-2:0], ge_w[k]};
        den_q[k]  <= den_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign out_valid_o = v_q[QW];
  assign quot_o      = lq_q[QW];
  assign sat_o       = sat_q[QW];
  assign side_o      = side_q[QW];

endmodule

/* hdl/voxel_importance_split_roulette_top.sv */
// ----------------------------------------------------------------------------
// voxel_importance_split_roulette_top: importance splitting / roulette
// Loads an importance table and decides split, kill or reweight for
// boundary crossings of tracks through a voxel grid.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the response is not stalled
// and returns exactly one result per item, in order. The path runs
// through the input register, two index stages, the table read, a
// classify/multiply stage, a kill-test stage, the split-count divider
// (clog2(MAX_SPLIT+1)+1 stages), the 32-bit weight divider (33 stages:
// an input stage, then one quotient bit per stage) and the output
// register. Every stage has its own valid bit and takes a new item
// whenever it is empty or its successor moves, so bubbles close up and a
// stalled response holds while earlier stages go on filling. The table is
// not cleared by reset: read an entry only after a load item has written
// it. Register writes (voxel counts) take effect for items accepted from
// the next cycle on and must be issued while no item is in flight.
// ----------------------------------------------------------------------------
module voxel_importance_split_roulette_top import vis_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int MAX_SPLIT   = MaxSplitDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vis_cfg_if.sink   cfg_i,
  vis_req_if.sink   req_i,
  vis_rsp_if.source rsp_o
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SQW = $clog2(MAX_SPLIT + 1);

  // --------------------------------------------------------------------------
  // Voxel count registers
  // --------------------------------------------------------------------------
  logic [CountW-1:0] count_x_q, count_y_q, count_z_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_x_q <= CountW'(1);
      count_y_q <= CountW'(1);
      count_z_q <= CountW'(1);
    end else if (cfg_i.valid) begin
      case (vis_reg_e'(cfg_i.index))
        REG_COUNT_X: count_x_q <= cfg_i.data;
        REG_COUNT_Y: count_y_q <= cfg_i.data;
        REG_COUNT_Z: count_z_q <= cfg_i.data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Index computation
  // --------------------------------------------------------------------------
  vis_req_t      req_w;
  logic          ix_valid, ix_ready;
  vis_ev_t       ix_ev;
  logic [AW-1:0] ix_pre_idx, ix_post_idx;

  assign req_w.req_type         = req_i.req_type;
  assign req_w.entry_index      = req_i.entry_index;
  assign req_w.entry_importance = req_i.entry_importance;
  assign req_w.crossing_limits  = req_i.crossing_limits;
  assign req_w.pre_x            = req_i.pre_x;
  assign req_w.pre_y            = req_i.pre_y;
  assign req_w.pre_z            = req_i.pre_z;
  assign req_w.post_x           = req_i.post_x;
  assign req_w.post_y           = req_i.post_y;
  assign req_w.post_z           = req_i.post_z;
  assign req_w.track_weight     = req_i.track_weight;
  assign req_w.uniform_random   = req_i.uniform_random;

  vis_index #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .count_x_i      (count_x_q),
    .count_y_i      (count_y_q),
    .count_z_i      (count_z_q),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .in_req_i       (req_w),
    .out_valid_o    (ix_valid),
    .out_ready_i    (ix_ready),
    .out_ev_o       (ix_ev),
    .out_pre_idx_o  (ix_pre_idx),
    .out_post_idx_o (ix_post_idx)
  );

  // --------------------------------------------------------------------------
  // Importance table: loads write, crossings read pre and post entries
  // --------------------------------------------------------------------------
  logic             tb_valid, tb_ready;
  vis_ev_t          tb_ev;
  logic [WordW-1:0] tb_pre, tb_post;

  vis_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ix_valid),
    .in_ready_o  (ix_ready),
    .ev_i        (ix_ev),
    .pre_idx_i   (ix_pre_idx),
    .post_idx_i  (ix_post_idx),
    .out_valid_o (tb_valid),
    .out_ready_i (tb_ready),
    .ev_o        (tb_ev),
    .pre_o       (tb_pre),
    .post_o      (tb_post)
  );

  // --------------------------------------------------------------------------
  // Classify stage: zero importance, rising importance; form both products
  // (random*pre for the kill test, weight*pre for the survival weight)
  // --------------------------------------------------------------------------
  logic     s4_v_q, s4_rdy, s5_v_q, s5_rdy, sd_in_ready;
  vis_mid_t s4_d, s4_q;

  always_comb begin
    s4_d.weight = tb_ev.weight;
    s4_d.post   = tb_post;
    s4_d.pre    = tb_pre;
    s4_d.prod_w = ProdW'(tb_ev.weight) * ProdW'(tb_pre);
    s4_d.prod_r = ProdW'(tb_ev.rnd) * ProdW'(tb_pre);
    if (tb_ev.decide) begin
      s4_d.act = tb_ev.act;
    end else if (tb_pre == '0 || tb_post == '0) begin
      s4_d.act = ACT_ERROR;
    end else if (tb_post > tb_pre) begin
      s4_d.act = ACT_SPLIT;
    end else begin
      s4_d.act = ACT_SURVIVE;
    end
  end

  assign s4_rdy   = !s4_v_q | s5_rdy;
  assign s5_rdy   = !s5_v_q | sd_in_ready;
  assign tb_ready = s4_rdy;

  // --------------------------------------------------------------------------
  // Kill stage: random > post/pre, written exactly as random*pre > post*2^32
  // --------------------------------------------------------------------------
  vis_sd_t          s5_d, s5_q;
  logic [WordW-1:0] s5_pre_q;

  always_comb begin
    s5_d.weight = s4_q.weight;
    s5_d.post   = s4_q.post;
    s5_d.prod_w = s4_q.prod_w;
    s5_d.act    = s4_q.act;
    if (s4_q.act == ACT_SURVIVE && s4_q.prod_r > {s4_q.post, WordW'(0)}) begin
      s5_d.act = ACT_KILL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (s4_rdy) s4_v_q <= tb_valid;
      if (s5_rdy) s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy) s4_q <= s4_d;
    if (s5_rdy) begin
      s5_q     <= s5_d;
      s5_pre_q <= s4_q.pre;
    end
  end

  // --------------------------------------------------------------------------
  // Split count: floor(post/pre), saturated at MAX_SPLIT
  // --------------------------------------------------------------------------
  logic                      sd_valid, sd_ready, sd_sat;
  logic [SQW-1:0]            sd_quot, split_n;
  logic [$bits(vis_sd_t)-1:0] sd_side_bits;
  vis_sd_t                   sd_side;

  vis_div #(
    .NW(WordW),
    .DW(WordW),
    .QW(SQW),
    .SW($bits(vis_sd_t))
  ) u_split_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s5_v_q),
    .in_ready_o  (sd_in_ready),
    .num_i       (s5_q.post),
    .den_i       (s5_pre_q),
    .side_i      (s5_q),
    .out_valid_o (sd_valid),
    .out_ready_i (sd_ready),
    .quot_o      (sd_quot),
    .sat_o       (sd_sat),
    .side_o      (sd_side_bits)
  );

  assign sd_side = vis_sd_t'(sd_side_bits);
  assign split_n = (sd_sat || sd_quot > SQW'(MAX_SPLIT)) ? SQW'(MAX_SPLIT) : sd_quot;

  // --------------------------------------------------------------------------
  // Weight divider: weight/n for a split, weight*pre/post for survival
  // --------------------------------------------------------------------------
  logic                       md_valid, md_ready, md_sat;
  logic [ProdW-1:0]           md_num;
  logic [WordW-1:0]           md_den, md_quot;
  vis_md_t                    md_in, md_side;
  logic [$bits(vis_md_t)-1:0] md_side_bits;

  assign md_num        = (sd_side.act == ACT_SPLIT) ? ProdW'(sd_side.weight) : sd_side.prod_w;
  assign md_den        = (sd_side.act == ACT_SPLIT) ? WordW'(split_n) : sd_side.post;
  assign md_in.act     = sd_side.act;
  assign md_in.weight  = sd_side.weight;
  assign md_in.copies  = CopyW'(split_n - SQW'(1));

  vis_div #(
    .NW(ProdW),
    .DW(WordW),
    .QW(WordW),
    .SW($bits(vis_md_t))
  ) u_weight_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sd_valid),
    .in_ready_o  (sd_ready),
    .num_i       (md_num),
    .den_i       (md_den),
    .side_i      (md_in),
    .out_valid_o (md_valid),
    .out_ready_i (md_ready),
    .quot_o      (md_quot),
    .sat_o       (md_sat),
    .side_o      (md_side_bits)
  );

  assign md_side = vis_md_t'(md_side_bits);

  // --------------------------------------------------------------------------
  // Output register: pick the weight by action, hold while stalled
  // --------------------------------------------------------------------------
  logic             rsp_v_q, rsp_rdy;
  vis_act_e         rsp_act_q;
  logic [WordW-1:0] rsp_weight_q, weight_d;
  logic [CopyW-1:0] rsp_copies_q, copies_d;

  always_comb begin
    copies_d = '0;
    case (md_side.act)
      ACT_NONE:    weight_d = md_side.weight;
      ACT_SPLIT: begin
        weight_d = md_quot;
        copies_d = md_side.copies;
      end
      ACT_SURVIVE: weight_d = md_sat ? '1 : md_quot;
      default:     weight_d = '0;
    endcase
  end

  assign rsp_rdy  = !rsp_v_q | rsp_o.ready;
  assign md_ready = rsp_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
    end else if (rsp_rdy) begin
      rsp_v_q <= md_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_rdy) begin
      rsp_act_q    <= md_side.act;
      rsp_weight_q <= weight_d;
      rsp_copies_q <= copies_d;
    end
  end

  assign rsp_o.valid        = rsp_v_q;
  assign rsp_o.action       = rsp_act_q;
  assign rsp_o.new_weight   = rsp_weight_q;
  assign rsp_o.extra_copies = rsp_copies_q;

endmodule

/* hdl/vis_checker.sv */
// ----------------------------------------------------------------------------
// vis_props: response port checks
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
module vis_props import vis_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_action_i,
  input logic [31:0] rsp_new_weight_i,
  input logic [5:0]  rsp_extra_copies_i
);

  // hold a stalled item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_action_i) &&
      $stable(rsp_new_weight_i) && $stable(rsp_extra_copies_i))
    else $error("response changed while stalled");

  // copies only come with a split
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_action_i != ACT_SPLIT |-> rsp_extra_copies_i == '0)
    else $error("extra copies without a split");

  // killed, loaded and error items carry no weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_action_i == ACT_KILL || rsp_action_i == ACT_LOAD ||
      rsp_action_i == ACT_ERROR) |-> rsp_new_weight_i == '0)
    else $error("nonzero weight on a weightless action");

endmodule

bind voxel_importance_split_roulette_top vis_props u_vis_props (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_action_i       (rsp_o.action),
  .rsp_new_weight_i   (rsp_o.new_weight),
  .rsp_extra_copies_i (rsp_o.extra_copies)
);
